// File: sv/lcnc_pkg.sv
// ----------------------------------------------------------------------------
// lcnc_pkg
// Shared widths, class codes and digit-count constants of the card number
// classifier.
// ----------------------------------------------------------------------------
package lcnc_pkg;

   localparam int CARD_WIDTH    = 54;
   localparam int DIGITS        = 17;
   localparam int DIGIT_WIDTH   = 4;
   localparam int BCD_WIDTH     = DIGITS * DIGIT_WIDTH;
   localparam int BITS_PER_STEP = 3;
   localparam int CONV_STEPS    = CARD_WIDTH / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int IDX_W         = $clog2(DIGITS);
   localparam int CLASS_WIDTH   = 2;
   localparam int COUNT_WIDTH   = 5;

   localparam logic [CLASS_WIDTH-1:0] CLASS_NONE  = 2'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_LEAD4 = 2'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_LEAD3 = 2'd2;
   localparam logic [CLASS_WIDTH-1:0] CLASS_LEAD5 = 2'd3;

   localparam logic [COUNT_WIDTH-1:0] LEN_13 = 5'd13;
   localparam logic [COUNT_WIDTH-1:0] LEN_15 = 5'd15;
   localparam logic [COUNT_WIDTH-1:0] LEN_16 = 5'd16;
   localparam logic [COUNT_WIDTH-1:0] LEN_MAX = COUNT_WIDTH'(DIGITS);

endpackage

// File: sv/lcnc_if.sv
// ----------------------------------------------------------------------------
// lcnc_req_if / lcnc_rsp_if
// Valid/ready channels of the card number classifier: card numbers in,
// classification results out.
// ----------------------------------------------------------------------------
interface lcnc_req_if;
   import lcnc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CARD_WIDTH-1:0] card_number;

   modport source (output valid, output card_number, input ready);
   modport sink   (input valid, input card_number, output ready);
endinterface

interface lcnc_rsp_if;
   import lcnc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CLASS_WIDTH-1:0] card_class;
   logic                   luhn_ok;
   logic [COUNT_WIDTH-1:0] digit_count;

   modport source (output valid, output card_class, output luhn_ok, output digit_count,
                   input ready);
   modport sink   (input valid, input card_class, input luhn_ok, input digit_count,
                   output ready);
endinterface

// File: sv/lcnc_bin2bcd.sv
// ----------------------------------------------------------------------------
// lcnc_bin2bcd
// Shift-and-add-3 binary to BCD converter, three binary bits per cycle.
// ----------------------------------------------------------------------------
module lcnc_bin2bcd (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lcnc_pkg::CARD_WIDTH-1:0] card_number,
   output logic [lcnc_pkg::BCD_WIDTH-1:0]  bcd,
   output logic                           done
);
   import lcnc_pkg::*;

   logic [CARD_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]  bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CARD_WIDTH-1:0] bin_step;
   logic [BCD_WIDTH-1:0]  bcd_step;

   function automatic logic [BCD_WIDTH-1:0] bcd_adjust(input logic [BCD_WIDTH-1:0] v);
      logic [BCD_WIDTH-1:0]   r;
      logic [DIGIT_WIDTH-1:0] d;
      r = v;
      for (int i = 0; i < DIGITS; i++) begin
         d = v[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         if (d >= DIGIT_WIDTH'(5)) begin
            r[i*DIGIT_WIDTH +: DIGIT_WIDTH] = d + DIGIT_WIDTH'(3);
         end
      end
      return r;
   endfunction

   always_comb begin
      bin_step = bin_ff;
      bcd_step = bcd_ff;
      for (int k = 0; k < BITS_PER_STEP; k++) begin
         bcd_step = bcd_adjust(bcd_step);
         bcd_step = {bcd_step[BCD_WIDTH-2:0], bin_step[CARD_WIDTH-1]};
         bin_step = {bin_step[CARD_WIDTH-2:0], 1'b0};
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = card_number;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in = bin_step;
         bcd_in = bcd_step;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_CNT_W'(CONV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign bcd  = bcd_ff;
   assign done = done_ff;

endmodule

// File: sv/luhn_card_number_classifier_unit.sv
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_unit
// Luhn mod-10 check and prefix/length classification of a card number.
// ----------------------------------------------------------------------------
// req_chan carries one card number per transaction (54-bit unsigned binary);
// rsp_chan returns one result per transaction: card_class, luhn_ok and
// digit_count. Bits of the card number are converted to decimal three per
// cycle, then the 17 decimal digits are scanned one per cycle, least
// significant first, accumulating the Luhn sum mod 10 and tracking the
// leading digits; a finish state then classifies and loads the output
// register once it is free. The unit works on one card number at a time
// and accepts the next one in the cycle after the result is loaded. The
// binary to decimal converter and the digit scanner take most of the time
// spent on each card number.
// The output register holds a result while the receiver stalls; the next card
// number is accepted and processed meanwhile, and its finished result waits
// in the scanner until the output register frees up.
// Synchronous reset returns the unit to idle and drops any pending result.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier_unit (
   input  logic      clock,
   input  logic      reset,
   lcnc_req_if.sink  req_chan,
   lcnc_rsp_if.source rsp_chan
);
   import lcnc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CONV   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [BCD_WIDTH-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [DIGIT_WIDTH-1:0] sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DIGIT_WIDTH-1:0] lead1_ff, lead1_in;
   logic [DIGIT_WIDTH-1:0] lead0_ff, lead0_in;
   logic [DIGIT_WIDTH-1:0] prev_ff, prev_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CLASS_WIDTH-1:0] out_class_ff, out_class_in;
   logic                   out_ok_ff, out_ok_in;
   logic [COUNT_WIDTH-1:0] out_count_ff, out_count_in;

   logic                   accept;
   logic                   conv_done;
   logic [BCD_WIDTH-1:0]   conv_bcd;
   logic [DIGIT_WIDTH-1:0] digit;
   logic [DIGIT_WIDTH-1:0] weighted;
   logic [DIGIT_WIDTH:0]   sum_wide;
   logic                   luhn_ok;
   logic [CLASS_WIDTH-1:0] card_class;
   logic                   lead4, lead3x, lead5x;

   assign accept = req_chan.valid && req_chan.ready;

   lcnc_bin2bcd u_bin2bcd (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .card_number (req_chan.card_number),
      .bcd         (conv_bcd),
      .done        (conv_done)
   );

   // Luhn weighting of the current digit
   always_comb begin
      digit = scan_ff[DIGIT_WIDTH-1:0];
      if (!idx_ff[0]) begin
         weighted = digit;
      end else if (digit <= DIGIT_WIDTH'(4)) begin
         weighted = {digit[DIGIT_WIDTH-2:0], 1'b0};
      end else begin
         weighted = {digit[DIGIT_WIDTH-2:0], 1'b0} - DIGIT_WIDTH'(9);
      end
      sum_wide = {1'b0, sum_ff} + {1'b0, weighted};
      if (sum_wide >= (DIGIT_WIDTH+1)'(10)) begin
         sum_wide = sum_wide - (DIGIT_WIDTH+1)'(10);
      end
   end

   // classify
   always_comb begin
      luhn_ok = (sum_ff == '0);
      lead4   = (lead1_ff == DIGIT_WIDTH'(4));
      lead3x  = (lead1_ff == DIGIT_WIDTH'(3))
                && (lead0_ff == DIGIT_WIDTH'(4) || lead0_ff == DIGIT_WIDTH'(7));
      lead5x  = (lead1_ff == DIGIT_WIDTH'(5))
                && (lead0_ff >= DIGIT_WIDTH'(1)) && (lead0_ff <= DIGIT_WIDTH'(5));
      card_class = CLASS_NONE;
      if (luhn_ok) begin
         if (count_ff == LEN_13 || count_ff == LEN_15) begin
            if (lead4) begin
               card_class = CLASS_LEAD4;
            end else if (lead3x) begin
               card_class = CLASS_LEAD3;
            end
         end else if (count_ff == LEN_16) begin
            if (lead4) begin
               card_class = CLASS_LEAD4;
            end else if (lead5x) begin
               card_class = CLASS_LEAD5;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      lead1_in     = lead1_ff;
      lead0_in     = lead0_ff;
      prev_in      = prev_ff;
      out_valid_in = out_valid_ff;
      out_class_in = out_class_ff;
      out_ok_in    = out_ok_ff;
      out_count_in = out_count_ff;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               scan_in  = conv_bcd;
               idx_in   = '0;
               sum_in   = '0;
               count_in = COUNT_WIDTH'(1);
               lead1_in = '0;
               lead0_in = '0;
               prev_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_in = {{DIGIT_WIDTH{1'b0}}, scan_ff[BCD_WIDTH-1:DIGIT_WIDTH]};
            sum_in  = sum_wide[DIGIT_WIDTH-1:0];
            prev_in = digit;
            idx_in  = idx_ff + 1'b1;
            if (digit != '0) begin
               count_in = COUNT_WIDTH'(idx_ff) + COUNT_WIDTH'(1);
               lead1_in = digit;
               lead0_in = prev_ff;
            end
            if (idx_ff == IDX_W'(DIGITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_class_in = card_class;
               out_ok_in    = luhn_ok;
               out_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      idx_ff       <= idx_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      lead1_ff     <= lead1_in;
      lead0_ff     <= lead0_in;
      prev_ff      <= prev_in;
      out_class_ff <= out_class_in;
      out_ok_ff    <= out_ok_in;
      out_count_ff <= out_count_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.card_class  = out_class_ff;
   assign rsp_chan.luhn_ok     = out_ok_ff;
   assign rsp_chan.digit_count = out_count_ff;

endmodule

// File: sv/lcnc_checker.sv
// ----------------------------------------------------------------------------
// lcnc_checker
// Port-level checks of the card number classifier, bound to the top level.
// ----------------------------------------------------------------------------
module lcnc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [lcnc_pkg::CLASS_WIDTH-1:0] card_class,
   input logic                             luhn_ok,
   input logic [lcnc_pkg::COUNT_WIDTH-1:0] digit_count
);
   import lcnc_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(card_class)
                                  && $stable(luhn_ok) && $stable(digit_count))
      else $error("stalled result changed");

   a_class_needs_luhn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && card_class != CLASS_NONE |-> luhn_ok)
      else $error("class given with failed checksum");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> digit_count != '0 && digit_count <= LEN_MAX)
      else $error("digit count out of range");

   a_class3_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && card_class == CLASS_LEAD5 |-> digit_count == LEN_16)
      else $error("prefix 51-55 class at wrong length");

   a_class2_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && card_class == CLASS_LEAD3 |-> digit_count == LEN_13
                                              || digit_count == LEN_15)
      else $error("prefix 34/37 class at wrong length");

endmodule

bind luhn_card_number_classifier_unit lcnc_checker u_lcnc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .card_class  (rsp_chan.card_class),
   .luhn_ok     (rsp_chan.luhn_ok),
   .digit_count (rsp_chan.digit_count)
);
